### hw/rtl/cec_pkg.sv
package cec_pkg;

  // Default sizing
  localparam int MAX_CIRCLES_DEF = 64;
  localparam int FRAC_BITS_DEF   = 16;

  // Iterative units: one result bit per step
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  // One stored circle
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [30:0] radius;
  } rec_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_I,
    OP_LOAD_J,
    OP_DIFF,
    OP_SQ,
    OP_CMP,
    OP_OV,
    OP_PROD,
    OP_DIV,
    OP_QSTORE,
    OP_DOT,
    OP_DOTSUM,
    OP_VEL,
    OP_UPD,
    OP_OUT
  } dp_op_t;

  // Memory write source
  typedef enum logic [1:0] {
    WR_LOAD,
    WR_I,
    WR_J
  } wsel_t;

  // Which quotient the divider produces
  typedef enum logic [1:0] {
    DSEL_PX,
    DSEL_PY,
    DSEL_NX,
    DSEL_NY
  } dsel_t;

  typedef struct packed {
    dp_op_t op;
    logic   mem_we;
    wsel_t  wsel;
    dsel_t  dsel;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic sqrt_busy;
    logic div_busy;
  } status_t;

endpackage

### hw/rtl/cec_if.sv
// Circle load channel
interface cec_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic        [30:0] radius;
  logic               last_circle;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, radius, last_circle,
                  input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, radius, last_circle,
                output ready);
endinterface

// Resolved circle channel
interface cec_out_if;
  logic               valid;
  logic               ready;
  logic        [5:0]  circle_index;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic               last_result;

  modport source (output valid, circle_index, new_pos_x, new_pos_y, new_vel_x,
                  new_vel_y, last_result, input ready);
  modport sink (input valid, circle_index, new_pos_x, new_pos_y, new_vel_x,
                new_vel_y, last_result, output ready);
endinterface

### hw/rtl/cec_ram.sv
module cec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cec_div.sv
module cec_div import cec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  // Restoring division, one quotient bit per cycle.
  // The quotient fits in 32 bits, so the upper dividend word is below the divisor.
  logic [31:0] rem;
  logic [31:0] dvd_lo;
  logic [4:0]  cnt;
  logic [32:0] trial;
  logic        take;

  assign trial = {rem, dvd_lo[31]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[63:32];
      dvd_lo   <= dividend[31:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      dvd_lo   <= {dvd_lo[30:0], 1'b0};
      quotient <= {quotient[30:0], take};
    end
  end

endmodule

### hw/rtl/cec_datapath.sv
module cec_datapath import cec_pkg::*; #(
  parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  input  logic [$clog2(MAX_CIRCLES)-1:0] addr,
  input  rec_t                           in_rec,
  output status_t                        status,
  output rec_t                           out_rec
);

  localparam int NW = FRAC_BITS + 2;   // unit normal component
  localparam int PW = FRAC_BITS + 34;  // velocity times normal
  localparam int DW = 35;              // dot product after scaling
  localparam int QW = FRAC_BITS + 37;  // normal times dot product

  // Signed divide by 2^FRAC_BITS, truncating toward zero
  function automatic logic signed [63:0] div_one(input logic signed [63:0] s);
    logic signed [63:0] m;
    m = s[63] ? -s : s;
    m = m >>> FRAC_BITS;
    return s[63] ? -m : m;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] s);
    if (s > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (s < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  rec_t rdata;
  rec_t wdata;
  rec_t rec_i;
  rec_t rec_j;

  logic [31:0] ax, ay, sr;
  logic        dx_neg, dy_neg;
  logic        early;
  logic [63:0] ax2, ay2, sr2;
  logic [64:0] d2;
  logic [30:0] ov;
  logic [62:0] pmx, pmy;
  logic [31:0] sep_len;

  logic signed [31:0] dpx, dpy;
  logic signed [NW-1:0] nx, ny, tx;
  logic signed [PW-1:0] a1, b1, c1, e1, a2, b2, c2, e2;
  logic signed [DW-1:0] dt1, dn1, dt2, dn2;
  logic signed [QW-1:0] m_t1x, m_n2x, m_t1y, m_n2y, m_t2x, m_n1x, m_t2y, m_n1y;

  logic [63:0] sq_v, sq_r, sq_bit;
  logic [64:0] sq_sum;
  logic [4:0]  sq_cnt;
  logic        sq_busy;

  logic [63:0] dvd;
  logic [31:0] quotient;
  logic        div_busy;
  logic        q_neg;
  logic signed [32:0] qmag, qs;

  // Circle store
  always_comb begin
    case (cmd.wsel)
      WR_I:    wdata = rec_i;
      WR_J:    wdata = rec_j;
      default: wdata = in_rec;
    endcase
  end

  cec_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_CIRCLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // Overlap test on the registered squares
  assign d2      = {1'b0, ax2} + {1'b0, ay2};
  assign sep_len = sq_r[31:0];
  assign tx      = -ny;

  assign status.skip      = early || d2[64] || (d2[63:0] >= sr2) || (d2 == '0);
  assign status.sqrt_busy = sq_busy;
  assign status.div_busy  = div_busy;

  // Integer square root, one result bit per cycle
  assign sq_sum = {1'b0, sq_r} + {1'b0, sq_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_cnt  <= '0;
    end else if (cmd.op == OP_CMP) begin
      sq_busy <= 1'b1;
      sq_cnt  <= '0;
    end else if (sq_busy) begin
      sq_cnt <= sq_cnt + 5'd1;
      if (sq_cnt == 5'(SQRT_STEPS - 1)) begin
        sq_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CMP) begin
      sq_v   <= d2[63:0];
      sq_r   <= '0;
      sq_bit <= SQRT_BIT0;
    end else if (sq_busy) begin
      if ({1'b0, sq_v} >= sq_sum) begin
        sq_v <= sq_v - sq_sum[63:0];
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Divider operand select and quotient sign
  always_comb begin
    case (cmd.dsel)
      DSEL_PX: dvd = {1'b0, pmx};
      DSEL_PY: dvd = {1'b0, pmy};
      DSEL_NX: dvd = 64'(ax) << FRAC_BITS;
      default: dvd = 64'(ay) << FRAC_BITS;
    endcase
  end

  assign q_neg = (cmd.dsel == DSEL_PY || cmd.dsel == DSEL_NY) ? dy_neg : dx_neg;
  assign qmag  = $signed({1'b0, quotient});
  assign qs    = q_neg ? -qmag : qmag;

  cec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV),
    .dividend (dvd),
    .divisor  (sep_len),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Pair arithmetic, one operation per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_I: rec_i <= rdata;
      OP_LOAD_J: rec_j <= rdata;
      OP_DIFF: begin
        ax <= (rec_i.pos_x >= rec_j.pos_x)
              ? 32'(33'(rec_i.pos_x) - 33'(rec_j.pos_x))
              : 32'(33'(rec_j.pos_x) - 33'(rec_i.pos_x));
        ay <= (rec_i.pos_y >= rec_j.pos_y)
              ? 32'(33'(rec_i.pos_y) - 33'(rec_j.pos_y))
              : 32'(33'(rec_j.pos_y) - 33'(rec_i.pos_y));
        dx_neg <= rec_i.pos_x < rec_j.pos_x;
        dy_neg <= rec_i.pos_y < rec_j.pos_y;
        sr <= 32'(rec_i.radius) + 32'(rec_j.radius);
      end
      OP_SQ: begin
        ax2   <= 64'(ax) * 64'(ax);
        ay2   <= 64'(ay) * 64'(ay);
        sr2   <= 64'(sr) * 64'(sr);
        early <= (ax >= sr) || (ay >= sr);
      end
      OP_OV: ov <= 31'((sr - sep_len) >> 1);
      OP_PROD: begin
        pmx <= 63'(ov) * 63'(ax);
        pmy <= 63'(ov) * 63'(ay);
      end
      OP_QSTORE: begin
        case (cmd.dsel)
          DSEL_PX: dpx <= qs[31:0];
          DSEL_PY: dpy <= qs[31:0];
          DSEL_NX: nx  <= qs[NW-1:0];
          default: ny  <= qs[NW-1:0];
        endcase
      end
      OP_DOT: begin
        a1 <= $signed(rec_i.vel_x) * tx;
        b1 <= $signed(rec_i.vel_y) * nx;
        c1 <= $signed(rec_i.vel_x) * nx;
        e1 <= $signed(rec_i.vel_y) * ny;
        a2 <= $signed(rec_j.vel_x) * tx;
        b2 <= $signed(rec_j.vel_y) * nx;
        c2 <= $signed(rec_j.vel_x) * nx;
        e2 <= $signed(rec_j.vel_y) * ny;
      end
      OP_DOTSUM: begin
        dt1 <= DW'(div_one(64'(a1) + 64'(b1)));
        dn1 <= DW'(div_one(64'(c1) + 64'(e1)));
        dt2 <= DW'(div_one(64'(a2) + 64'(b2)));
        dn2 <= DW'(div_one(64'(c2) + 64'(e2)));
      end
      OP_VEL: begin
        m_t1x <= tx * dt1;
        m_n2x <= nx * dn2;
        m_t1y <= nx * dt1;
        m_n2y <= ny * dn2;
        m_t2x <= tx * dt2;
        m_n1x <= nx * dn1;
        m_t2y <= nx * dt2;
        m_n1y <= ny * dn1;
      end
      OP_UPD: begin
        rec_i.pos_x <= sat32(64'(rec_i.pos_x) + 64'(dpx));
        rec_i.pos_y <= sat32(64'(rec_i.pos_y) + 64'(dpy));
        rec_j.pos_x <= sat32(64'(rec_j.pos_x) - 64'(dpx));
        rec_j.pos_y <= sat32(64'(rec_j.pos_y) - 64'(dpy));
        rec_i.vel_x <= sat32(div_one(64'(m_t1x) + 64'(m_n2x)));
        rec_i.vel_y <= sat32(div_one(64'(m_t1y) + 64'(m_n2y)));
        rec_j.vel_x <= sat32(div_one(64'(m_t2x) + 64'(m_n1x)));
        rec_j.vel_y <= sat32(div_one(64'(m_t2y) + 64'(m_n1y)));
      end
      OP_OUT: out_rec <= rdata;
      default: ;
    endcase
  end

endmodule

### hw/rtl/cec_ctrl.sv
module cec_ctrl import cec_pkg::*; #(
  parameter int MAX_CIRCLES = MAX_CIRCLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_last,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_last,
  output logic [5:0]                     out_index,
  output cmd_t                           cmd,
  output logic [$clog2(MAX_CIRCLES)-1:0] addr,
  input  status_t                        status
);

  localparam int IW = $clog2(MAX_CIRCLES);
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  typedef enum logic [21:0] {
    S_LOAD     = 22'h000001,
    S_PAIR     = 22'h000002,
    S_RD_I     = 22'h000004,
    S_RD_J     = 22'h000008,
    S_CAP_J    = 22'h000010,
    S_DIFF     = 22'h000020,
    S_SQ       = 22'h000040,
    S_CMP      = 22'h000080,
    S_SQRT     = 22'h000100,
    S_OV       = 22'h000200,
    S_PROD     = 22'h000400,
    S_DIV      = 22'h000800,
    S_DIV_WAIT = 22'h001000,
    S_DOT      = 22'h002000,
    S_DOTSUM   = 22'h004000,
    S_VEL      = 22'h008000,
    S_UPD      = 22'h010000,
    S_WR_I     = 22'h020000,
    S_WR_J     = 22'h040000,
    S_OUT_RD   = 22'h080000,
    S_OUT_CAP  = 22'h100000,
    S_OUT_WAIT = 22'h200000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  dsel_t         dsel, dsel_next;
  logic [CW-1:0] i_adv, j_adv;
  logic          full;
  logic [IW+5:0] idx_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      i     <= '0;
      j     <= '0;
      dsel  <= DSEL_PX;
    end else begin
      state <= state_next;
      count <= count_next;
      i     <= i_next;
      j     <= j_next;
      dsel  <= dsel_next;
    end
  end

  // Next ordered pair, j inner
  always_comb begin
    if (j + CW'(1) == count) begin
      j_adv = '0;
      i_adv = i + CW'(1);
    end else begin
      j_adv = j + CW'(1);
      i_adv = i;
    end
  end

  assign full      = count == CW'(MAX_CIRCLES);
  assign idx_wide  = (IW + 6)'(i[IW-1:0]);
  assign out_index = idx_wide[5:0];
  assign out_last  = i + CW'(1) == count;

  // Sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    i_next     = i;
    j_next     = j;
    dsel_next  = dsel;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    addr       = i[IW-1:0];
    cmd        = '{op: OP_NONE, mem_we: 1'b0, wsel: WR_LOAD, dsel: dsel};

    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        addr     = count[IW-1:0];
        if (in_valid) begin
          if (!full) begin
            cmd.mem_we = 1'b1;
            count_next = count + CW'(1);
          end
          if (in_last) begin
            i_next     = '0;
            j_next     = '0;
            state_next = S_PAIR;
          end
        end
      end
      S_PAIR: begin
        if (i == count) begin
          i_next     = '0;
          state_next = S_OUT_RD;
        end else if (i == j) begin
          i_next = i_adv;
          j_next = j_adv;
        end else begin
          state_next = S_RD_I;
        end
      end
      S_RD_I: state_next = S_RD_J;
      S_RD_J: begin
        addr       = j[IW-1:0];
        cmd.op     = OP_LOAD_I;
        state_next = S_CAP_J;
      end
      S_CAP_J: begin
        cmd.op     = OP_LOAD_J;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.op = OP_CMP;
        if (status.skip) begin
          i_next     = i_adv;
          j_next     = j_adv;
          state_next = S_PAIR;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!status.sqrt_busy) begin
          state_next = S_OV;
        end
      end
      S_OV: begin
        cmd.op     = OP_OV;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.op     = OP_PROD;
        dsel_next  = DSEL_PX;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op     = OP_DIV;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = OP_QSTORE;
          if (dsel == DSEL_NY) begin
            state_next = S_DOT;
          end else begin
            dsel_next  = dsel_t'(dsel + 2'd1);
            state_next = S_DIV;
          end
        end
      end
      S_DOT: begin
        cmd.op     = OP_DOT;
        state_next = S_DOTSUM;
      end
      S_DOTSUM: begin
        cmd.op     = OP_DOTSUM;
        state_next = S_VEL;
      end
      S_VEL: begin
        cmd.op     = OP_VEL;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = S_WR_I;
      end
      S_WR_I: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WR_I;
        state_next = S_WR_J;
      end
      S_WR_J: begin
        addr       = j[IW-1:0];
        cmd.mem_we = 1'b1;
        cmd.wsel   = WR_J;
        i_next     = i_adv;
        j_next     = j_adv;
        state_next = S_PAIR;
      end
      S_OUT_RD: state_next = S_OUT_CAP;
      S_OUT_CAP: begin
        cmd.op     = OP_OUT;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_last) begin
            count_next = '0;
            i_next     = '0;
            state_next = S_LOAD;
          end else begin
            i_next     = i + CW'(1);
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

### hw/rtl/circle_elastic_collision_pass_core.sv
// Loading: one circle per cycle. The circle marked last starts the pass.
// Pass: every ordered pair of distinct circles in turn; a pair that misses is
// left at the compare, a colliding pair runs a 32-step square root, then four
// 32-step divisions in the shared divider. Same-index pairs are passed over.
// Output: read, capture, hold until taken; loading resumes after the last one.
// Synchronous active-high reset empties the set; the circle store is not cleared.
module circle_elastic_collision_pass_core import cec_pkg::*; #(
  parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cec_in_if.sink     circles,
  cec_out_if.source  results
);

  cmd_t                           cmd;
  status_t                        status;
  logic [$clog2(MAX_CIRCLES)-1:0] addr;
  rec_t                           in_rec;
  rec_t                           out_rec;

  assign in_rec = '{pos_x:  circles.pos_x,
                    pos_y:  circles.pos_y,
                    vel_x:  circles.vel_x,
                    vel_y:  circles.vel_y,
                    radius: circles.radius};

  cec_ctrl #(
    .MAX_CIRCLES (MAX_CIRCLES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (circles.valid),
    .in_last   (circles.last_circle),
    .in_ready  (circles.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_last  (results.last_result),
    .out_index (results.circle_index),
    .cmd       (cmd),
    .addr      (addr),
    .status    (status)
  );

  cec_datapath #(
    .MAX_CIRCLES (MAX_CIRCLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .addr    (addr),
    .in_rec  (in_rec),
    .status  (status),
    .out_rec (out_rec)
  );

  assign results.new_pos_x = out_rec.pos_x;
  assign results.new_pos_y = out_rec.pos_y;
  assign results.new_vel_x = out_rec.vel_x;
  assign results.new_vel_y = out_rec.vel_y;

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(results.valid && circles.ready))
    else $error("load and emit active together");

  // The last result hands control back to loading
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.last_result) |=> circles.ready)
    else $error("no return to loading after last result");

  // Square root and divider are never busy together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.sqrt_busy && status.div_busy))
    else $error("square root and divider overlap");

endmodule
